// ----- rtl/cldh_pkg.sv -----
// ----------------------------------------------------------------------------
// cldh_pkg
// Class codes, event codes, alert actions and reset values for the class
// label debouncer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cldh_pkg;

    localparam int SCORE_W = 16;
    localparam int CLASS_W = 2;
    localparam int EVENT_W = 2;
    localparam int ACTION_W = 2;
    localparam int CNT_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CLASS_W-1:0] CLS_NONE = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_HORN = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_SIREN = 2'd2;
    localparam logic [CLASS_W-1:0] CLS_UNUSED = 2'd3;

    localparam logic [EVENT_W-1:0] EV_NONE = 2'd0;
    localparam logic [EVENT_W-1:0] EV_START = 2'd1;
    localparam logic [EVENT_W-1:0] EV_ACTIVE = 2'd2;
    localparam logic [EVENT_W-1:0] EV_END = 2'd3;

    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RAISE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVATE_HITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MISSES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_MISSES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUPPORT_THRESHOLD = 2'd3;

    localparam logic [3:0] ACTIVATE_HITS_RST = 4'd3;
    localparam logic [3:0] HOLD_MISSES_RST = 4'd2;
    localparam logic [3:0] RELEASE_MISSES_RST = 4'd4;
    localparam logic [SCORE_W-1:0] SUPPORT_THRESHOLD_RST = 16'd39322;

    localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

    function automatic logic [SCORE_W-1:0] score_of(
        input logic [CLASS_W-1:0] cls,
        input logic [SCORE_W-1:0] bg,
        input logic [SCORE_W-1:0] horn,
        input logic [SCORE_W-1:0] siren
    );
        logic [SCORE_W-1:0] s;
        unique case (cls)
            CLS_NONE:  s = bg;
            CLS_HORN:  s = horn;
            CLS_SIREN: s = siren;
            default:   s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/class_label_debounce_hysteresis.sv -----
// ----------------------------------------------------------------------------
// class_label_debounce_hysteresis
// An accepted input beat passes the input register, then the result register.
// Throughput: one beat per cycle when out_ready does not stall the result stage,
// set by the single pass of compare logic between the two registers.
// Reset clears the debounce state, the pipeline valids and loads the
// configuration registers with their default values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module class_label_debounce_hysteresis
    import cldh_pkg::*;
(
    input  wire                    clk,
    input  wire                    rst_n,

    input  wire                    cfg_we,
    input  wire [CFG_IDX_W-1:0]    cfg_index,
    input  wire [CFG_DATA_W-1:0]   cfg_data,

    input  wire                    in_valid,
    output logic                   in_ready,
    input  wire [CLASS_W-1:0]      top_class,
    input  wire [SCORE_W-1:0]      background_score,
    input  wire [SCORE_W-1:0]      horn_prob,
    input  wire [SCORE_W-1:0]      siren_prob,

    output logic                   out_valid,
    input  wire                    out_ready,
    output logic [CLASS_W-1:0]     raw_class,
    output logic [CLASS_W-1:0]     stable_class,
    output logic [EVENT_W-1:0]     event_code,
    output logic                   alert_new,
    output logic [SCORE_W-1:0]     confidence,
    output logic [ACTION_W-1:0]    alert_action
);

    // Configuration.
    logic [3:0]          activate_hits_reg;
    logic [3:0]          hold_misses_reg;
    logic [3:0]          release_misses_reg;
    logic [SCORE_W-1:0]  support_threshold_reg;

    // Debounce state.
    logic [CLASS_W-1:0]  stable_reg, stable_next;
    logic [CLASS_W-1:0]  pending_reg, pending_next;
    logic [CNT_W-1:0]    hit_reg, hit_next;
    logic [CNT_W-1:0]    miss_reg, miss_next;
    logic                alert_reg, alert_next;

    // Input stage.
    logic                s1_valid_reg;
    logic [CLASS_W-1:0]  s1_top_reg;
    logic [SCORE_W-1:0]  s1_bg_reg, s1_horn_reg, s1_siren_reg;

    // Result stage.
    logic                out_valid_reg;
    logic [CLASS_W-1:0]  raw_reg, raw_next;
    logic [CLASS_W-1:0]  st_out_reg, st_out_next;
    logic [EVENT_W-1:0]  ev_reg, ev_next;
    logic                fired_reg, fired_next;
    logic [SCORE_W-1:0]  conf_reg, conf_next;
    logic [ACTION_W-1:0] action_reg, action_next;

    logic advance;
    logic step;

    assign advance  = !out_valid_reg || out_ready;
    assign step     = s1_valid_reg && advance;
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            activate_hits_reg     <= ACTIVATE_HITS_RST;
            hold_misses_reg       <= HOLD_MISSES_RST;
            release_misses_reg    <= RELEASE_MISSES_RST;
            support_threshold_reg <= SUPPORT_THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ACTIVATE_HITS:     activate_hits_reg <= cfg_data[3:0];
                REG_HOLD_MISSES:       hold_misses_reg <= cfg_data[3:0];
                REG_RELEASE_MISSES:    release_misses_reg <= cfg_data[3:0];
                REG_SUPPORT_THRESHOLD: support_threshold_reg <= cfg_data[SCORE_W-1:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        logic [CLASS_W-1:0] raw;
        logic [CLASS_W-1:0] eff;
        logic [SCORE_W-1:0] st_score;
        logic [SCORE_W-1:0] pend_score;
        logic [CNT_W-1:0]   hit_trk;
        logic [CLASS_W-1:0] pend_trk;
        logic [CNT_W-1:0]   miss_inc;

        raw = (s1_top_reg == CLS_UNUSED) ? CLS_NONE : s1_top_reg;
        st_score = score_of(stable_reg, s1_bg_reg, s1_horn_reg, s1_siren_reg);
        pend_score = score_of(pending_reg, s1_bg_reg, s1_horn_reg, s1_siren_reg);

        // An empty top class falls back to the stable class, then the pending one.
        eff = raw;
        if (raw == CLS_NONE)
        begin
            if (stable_reg != CLS_NONE && st_score >= support_threshold_reg)
                eff = stable_reg;
            else if (pending_reg != CLS_NONE && pend_score >= support_threshold_reg)
                eff = pending_reg;
        end

        // Pending tracking as it would look after this beat.
        if (eff == CLS_NONE)
        begin
            pend_trk = CLS_NONE;
            hit_trk  = '0;
        end
        else if (pending_reg == eff)
        begin
            pend_trk = pending_reg;
            hit_trk  = sat_inc(hit_reg);
        end
        else
        begin
            pend_trk = eff;
            hit_trk  = CNT_W'(1);
        end

        miss_inc = sat_inc(miss_reg);

        stable_next  = stable_reg;
        pending_next = pend_trk;
        hit_next     = hit_trk;
        miss_next    = miss_reg;
        alert_next   = alert_reg;

        raw_next    = raw;
        st_out_next = stable_reg;
        ev_next     = EV_NONE;
        fired_next  = 1'b0;
        conf_next   = score_of(eff, s1_bg_reg, s1_horn_reg, s1_siren_reg);

        if (stable_reg == CLS_NONE)
        begin
            miss_next = '0;
            if (eff != CLS_NONE && hit_trk >= CNT_W'(activate_hits_reg))
            begin
                stable_next  = eff;
                pending_next = CLS_NONE;
                hit_next     = '0;
                st_out_next  = eff;
                ev_next      = EV_START;
                conf_next    = score_of(eff, s1_bg_reg, s1_horn_reg, s1_siren_reg);
                if (!alert_reg)
                begin
                    fired_next = 1'b1;
                    alert_next = 1'b1;
                end
            end
        end
        else if (eff == stable_reg)
        begin
            miss_next    = '0;
            pending_next = CLS_NONE;
            hit_next     = '0;
            ev_next      = EV_ACTIVE;
            conf_next    = st_score;
        end
        else
        begin
            miss_next = miss_inc;
            if (miss_inc <= CNT_W'(hold_misses_reg))
            begin
                ev_next   = EV_ACTIVE;
                conf_next = st_score;
            end
            else if (miss_inc >= CNT_W'(release_misses_reg))
            begin
                // Release; the pending class carries over with a fresh count.
                stable_next = CLS_NONE;
                miss_next   = '0;
                alert_next  = 1'b0;
                st_out_next = CLS_NONE;
                ev_next     = EV_END;
                conf_next   = '0;
                hit_next    = (pend_trk == CLS_NONE) ? '0 : CNT_W'(1);
            end
        end

        if (fired_next)
            action_next = ACT_RAISE;
        else if (ev_next == EV_END)
            action_next = ACT_CLEAR;
        else
            action_next = ACT_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            stable_reg    <= CLS_NONE;
            pending_reg   <= CLS_NONE;
            hit_reg       <= '0;
            miss_reg      <= '0;
            alert_reg     <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= s1_valid_reg;
            if (step)
            begin
                stable_reg  <= stable_next;
                pending_reg <= pending_next;
                hit_reg     <= hit_next;
                miss_reg    <= miss_next;
                alert_reg   <= alert_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_top_reg   <= top_class;
            s1_bg_reg    <= background_score;
            s1_horn_reg  <= horn_prob;
            s1_siren_reg <= siren_prob;
        end
        if (step)
        begin
            raw_reg    <= raw_next;
            st_out_reg <= st_out_next;
            ev_reg     <= ev_next;
            fired_reg  <= fired_next;
            conf_reg   <= conf_next;
            action_reg <= action_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign raw_class    = raw_reg;
    assign stable_class = st_out_reg;
    assign event_code   = ev_reg;
    assign alert_new    = fired_reg;
    assign confidence   = conf_reg;
    assign alert_action = action_reg;

endmodule

`default_nettype wire

// ----- verif/tb_class_label_debounce_hysteresis.sv -----
// ----------------------------------------------------------------------------
// tb_class_label_debounce_hysteresis
// Self-checking bench for the class label debouncer. A short table of
// classifier readings covers the corner cases, then random runs of horn and
// siren hits with gaps of misses follow under several register settings.
// Every result beat is checked against the table's expected result or an in-bench model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_class_label_debounce_hysteresis
    import cldh_pkg::*;
();

    localparam int PLAN_LEN = 23;
    localparam int PHASES = 8;
    localparam int READINGS_PER_PHASE = 200;
    localparam int LONG_HOLD = 120;
    localparam longint LIMIT_NS = 5_000_000;

    typedef struct packed {
        logic [CLASS_W-1:0] top;
        logic [SCORE_W-1:0] bg;
        logic [SCORE_W-1:0] horn;
        logic [SCORE_W-1:0] siren;
    } reading_t;

    typedef struct packed {
        logic [CLASS_W-1:0]  raw;
        logic [CLASS_W-1:0]  stable;
        logic [EVENT_W-1:0]  ev;
        logic                fired;
        logic [SCORE_W-1:0]  conf;
        logic [ACTION_W-1:0] action;
    } verdict_t;

    typedef enum logic [0:0] {ROW_READ, ROW_ZERO_COUNTS} row_kind_e;

    typedef struct packed {
        row_kind_e kind;
        reading_t  rd;
        logic      typed;
        verdict_t  want;
    } row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [CLASS_W-1:0]    top_class = '0;
    logic [SCORE_W-1:0]    background_score = '0;
    logic [SCORE_W-1:0]    horn_prob = '0;
    logic [SCORE_W-1:0]    siren_prob = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [CLASS_W-1:0]    raw_class;
    logic [CLASS_W-1:0]    stable_class;
    logic [EVENT_W-1:0]    event_code;
    logic                  alert_new;
    logic [SCORE_W-1:0]    confidence;
    logic [ACTION_W-1:0]   alert_action;

    class_label_debounce_hysteresis DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Register copies and debounce state of the bench model.
    logic [3:0]         cfg_activate = ACTIVATE_HITS_RST;
    logic [3:0]         cfg_hold = HOLD_MISSES_RST;
    logic [3:0]         cfg_release = RELEASE_MISSES_RST;
    logic [SCORE_W-1:0] cfg_threshold = SUPPORT_THRESHOLD_RST;
    logic [CLASS_W-1:0] cls_stable = CLS_NONE;
    logic [CLASS_W-1:0] cls_pending = CLS_NONE;
    logic [CNT_W-1:0]   hits = '0;
    logic [CNT_W-1:0]   misses = '0;
    logic               alert_on = 1'b0;

    verdict_t verdicts[$];
    verdict_t due;
    logic     tx_quiet = 1'b0;
    int       errors = 0;
    int       readings_sent = 0;
    int       results_seen = 0;
    int       starts_seen = 0;
    int       ends_seen = 0;
    int       lingers_seen = 0;
    int       settings_used = 0;

    // Random run generator state.
    logic [CLASS_W-1:0] run_cls = CLS_HORN;
    int                 run_left = 0;
    int                 gap_left = 0;

    row_t plan [PLAN_LEN] = '{
        '{ROW_READ, '{CLS_NONE, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
          '{CLS_NONE, CLS_NONE, EV_NONE, 1'b0, 16'h0000, ACT_NONE}},
        '{ROW_READ, '{CLS_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
          '{CLS_NONE, CLS_NONE, EV_NONE, 1'b0, 16'hFFFF, ACT_NONE}},
        '{ROW_READ, '{CLS_HORN, 16'h0000, 16'hFFFF, 16'h0000}, 1'b0, '0},
        '{ROW_READ, '{CLS_HORN, 16'h0000, 16'hFFFF, 16'h0000}, 1'b0, '0},
        '{ROW_READ, '{CLS_HORN, 16'h0000, 16'hFFFF, 16'h0000}, 1'b1,
          '{CLS_HORN, CLS_HORN, EV_START, 1'b1, 16'hFFFF, ACT_RAISE}},
        '{ROW_READ, '{CLS_HORN, 16'h0000, 16'hFFFF, 16'h0000}, 1'b0, '0},
        // Empty top class, horn score exactly at the threshold.
        '{ROW_READ, '{CLS_NONE, 16'hFFFF, 16'h999A, 16'h0000}, 1'b0, '0},
        '{ROW_READ, '{CLS_NONE, 16'h0000, 16'h9999, 16'hFFFF}, 1'b0, '0},
        '{ROW_READ, '{CLS_SIREN, 16'h0000, 16'h0000, 16'hFFFF}, 1'b0, '0},
        // Past the hold count but short of release.
        '{ROW_READ, '{CLS_SIREN, 16'h0000, 16'h0000, 16'hFFFF}, 1'b0, '0},
        '{ROW_READ, '{CLS_NONE, 16'h0000, 16'h0000, 16'h999A}, 1'b1,
          '{CLS_NONE, CLS_NONE, EV_END, 1'b0, 16'h0000, ACT_CLEAR}},
        '{ROW_READ, '{CLS_SIREN, 16'h0000, 16'h0000, 16'h8000}, 1'b0, '0},
        '{ROW_READ, '{CLS_UNUSED, 16'h0000, 16'h0000, 16'hFFFF}, 1'b1,
          '{CLS_NONE, CLS_SIREN, EV_START, 1'b1, 16'hFFFF, ACT_RAISE}},
        '{ROW_READ, '{CLS_NONE, 16'h1234, 16'hFFFF, 16'h0000}, 1'b0, '0},
        '{ROW_ZERO_COUNTS, '0, 1'b0, '0},
        '{ROW_READ, '{CLS_NONE, 16'h0000, 16'h0000, 16'hFFFE}, 1'b1,
          '{CLS_NONE, CLS_NONE, EV_END, 1'b0, 16'h0000, ACT_CLEAR}},
        '{ROW_READ, '{CLS_HORN, 16'h0000, 16'h5555, 16'h0000}, 1'b1,
          '{CLS_HORN, CLS_HORN, EV_START, 1'b1, 16'h5555, ACT_RAISE}},
        '{ROW_READ, '{CLS_NONE, 16'h0000, 16'hFFFF, 16'h0000}, 1'b0, '0},
        '{ROW_READ, '{CLS_SIREN, 16'hAAAA, 16'h0000, 16'h0001}, 1'b1,
          '{CLS_SIREN, CLS_NONE, EV_END, 1'b0, 16'h0000, ACT_CLEAR}},
        '{ROW_READ, '{CLS_NONE, 16'hFFFF, 16'h0000, 16'hFFFF}, 1'b0, '0},
        '{ROW_READ, '{CLS_HORN, 16'h0000, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
        '{ROW_READ, '{CLS_NONE, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{ROW_READ, '{CLS_HORN, 16'h8000, 16'h7FFF, 16'h0000}, 1'b0, '0}
    };

    function automatic logic [SCORE_W-1:0] class_score(input logic [CLASS_W-1:0] cls,
                                                       input reading_t r);
        logic [SCORE_W-1:0] s;
        case (cls)
            CLS_NONE:  s = r.bg;
            CLS_HORN:  s = r.horn;
            CLS_SIREN: s = r.siren;
            default:   s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic void count_hit(input logic [CLASS_W-1:0] cls);
        if (cls_pending == cls)
            hits = bump(hits);
        else
        begin
            cls_pending = cls;
            hits = 8'd1;
        end
    endfunction

    // Advances the model by one reading and returns the result it should cause.
    function automatic verdict_t debounce_next(input reading_t r);
        logic [CLASS_W-1:0] raw;
        logic [CLASS_W-1:0] eff;
        verdict_t v;
        raw = (r.top == CLS_UNUSED) ? CLS_NONE : r.top;
        eff = raw;
        if (raw == CLS_NONE)
        begin
            if (cls_stable != CLS_NONE && class_score(cls_stable, r) >= cfg_threshold)
                eff = cls_stable;
            else if (cls_pending != CLS_NONE && class_score(cls_pending, r) >= cfg_threshold)
                eff = cls_pending;
        end
        v.raw = raw;
        v.stable = cls_stable;
        v.ev = EV_NONE;
        v.fired = 1'b0;
        v.conf = class_score(eff, r);
        if (cls_stable == CLS_NONE)
        begin
            misses = '0;
            if (eff == CLS_NONE)
            begin
                cls_pending = CLS_NONE;
                hits = '0;
            end
            else
            begin
                count_hit(eff);
                if (hits >= {4'd0, cfg_activate})
                begin
                    cls_stable = eff;
                    cls_pending = CLS_NONE;
                    hits = '0;
                    v.stable = eff;
                    v.ev = EV_START;
                    v.conf = class_score(eff, r);
                    if (!alert_on)
                    begin
                        v.fired = 1'b1;
                        alert_on = 1'b1;
                    end
                end
            end
        end
        else if (eff == cls_stable)
        begin
            misses = '0;
            cls_pending = CLS_NONE;
            hits = '0;
            v.ev = EV_ACTIVE;
            v.conf = class_score(cls_stable, r);
        end
        else
        begin
            misses = bump(misses);
            if (eff == CLS_NONE)
            begin
                cls_pending = CLS_NONE;
                hits = '0;
            end
            else
                count_hit(eff);
            if (misses <= {4'd0, cfg_hold})
            begin
                v.ev = EV_ACTIVE;
                v.conf = class_score(cls_stable, r);
            end
            else if (misses >= {4'd0, cfg_release})
            begin
                cls_stable = CLS_NONE;
                misses = '0;
                alert_on = 1'b0;
                v.stable = CLS_NONE;
                v.ev = EV_END;
                v.conf = '0;
                hits = (cls_pending == CLS_NONE) ? 8'd0 : 8'd1;
            end
        end
        v.action = v.fired ? ACT_RAISE : ((v.ev == EV_END) ? ACT_CLEAR : ACT_NONE);
        return v;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic logic [SCORE_W-1:0] rand_score();
        return 16'($urandom());
    endfunction

    function automatic logic [SCORE_W-1:0] over_threshold();
        return 16'($urandom_range(32'hFFFF, cfg_threshold));
    endfunction

    // With a zero threshold every score is supported, so any value will do.
    function automatic logic [SCORE_W-1:0] under_threshold();
        if (cfg_threshold == '0)
            return rand_score();
        return 16'($urandom_range(cfg_threshold - 1, 0));
    endfunction

    // Mostly runs of one class with supported scores, separated by gaps of
    // misses, with some plain noise mixed in.
    task automatic make_reading(output reading_t r);
        logic [SCORE_W-1:0] s;
        r.top = 2'($urandom_range(0, 3));
        r.bg = rand_score();
        r.horn = rand_score();
        r.siren = rand_score();
        if ($urandom_range(0, 99) < 12)
            return;
        if (run_left == 0 && gap_left == 0)
        begin
            run_cls = ($urandom_range(0, 1) == 0) ? CLS_HORN : CLS_SIREN;
            run_left = $urandom_range(1, 20);
            gap_left = $urandom_range(0, 20);
        end
        if (run_left != 0)
        begin
            run_left--;
            r.bg = under_threshold();
            // An empty top class has to lean on the score of the run's class.
            case ($urandom_range(0, 7))
                0:       r.top = CLS_NONE;
                1:       r.top = CLS_UNUSED;
                default: r.top = run_cls;
            endcase
            s = ($urandom_range(0, 7) == 0) ? under_threshold() : over_threshold();
            if (run_cls == CLS_HORN)
            begin
                r.horn = s;
                r.siren = under_threshold();
            end
            else
            begin
                r.siren = s;
                r.horn = under_threshold();
            end
        end
        else
        begin
            gap_left--;
            r.top = ($urandom_range(0, 5) == 0) ?
                    ((run_cls == CLS_HORN) ? CLS_SIREN : CLS_HORN) : CLS_NONE;
            r.horn = under_threshold();
            r.siren = under_threshold();
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send(input reading_t r, input logic typed, input verdict_t want);
        int gap;
        verdict_t predicted;
        gap = tx_quiet ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        top_class <= r.top;
        background_score <= r.bg;
        horn_prob <= r.horn;
        siren_prob <= r.siren;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = debounce_next(r);
        verdicts.push_back(typed ? want : predicted);
        readings_sent++;
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (verdicts.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
    endtask

    task automatic configure(input logic [3:0] act, input logic [3:0] hold,
                             input logic [3:0] rel, input logic [15:0] thr);
        logic [15:0] junk;
        // The upper bits of the narrow registers are don't-care.
        junk = rand_score();
        write_reg(REG_ACTIVATE_HITS, {junk[15:4], act});
        write_reg(REG_HOLD_MISSES, {junk[11:0], hold});
        write_reg(REG_RELEASE_MISSES, {junk[7:0], junk[15:12], rel});
        write_reg(REG_SUPPORT_THRESHOLD, thr);
        cfg_we <= 1'b0;
        cfg_activate = act;
        cfg_hold = hold;
        cfg_release = rel;
        cfg_threshold = thr;
        settings_used++;
    endtask

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (verdicts.size() == 0)
            begin
                $error("result beat arrived with nothing outstanding");
                errors++;
            end
            else
            begin
                due = verdicts.pop_front();
                results_seen++;
                if (due.ev == EV_START)
                    starts_seen++;
                if (due.ev == EV_END)
                    ends_seen++;
                if (due.ev == EV_NONE && due.stable != CLS_NONE)
                    lingers_seen++;
                check_field("raw_class", 16'(due.raw), 16'(raw_class));
                check_field("stable_class", 16'(due.stable), 16'(stable_class));
                check_field("event_code", 16'(due.ev), 16'(event_code));
                check_field("alert_new", 16'(due.fired), 16'(alert_new));
                check_field("confidence", due.conf, confidence);
                check_field("alert_action", 16'(due.action), 16'(alert_action));
            end
        end
    end

    // Result side: random stalls, quiet stretches, and two long hold-offs
    // that back the pipeline up into the input.
    initial
    begin : sink
        int beats;
        int wait_cycles;
        logic rx_quiet;
        beats = 0;
        rx_quiet = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (beats % 64 == 0)
                rx_quiet = ($urandom_range(0, 2) == 0);
            if (beats == 350 || beats == 1150)
                wait_cycles = LONG_HOLD;
            else
                wait_cycles = rx_quiet ? 0 : $urandom_range(0, 15);
            if (wait_cycles != 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            beats++;
            @(negedge clk);
        end
    end

    initial
    begin
        #(LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        reading_t r;
        logic [3:0] act;
        logic [3:0] hold;
        logic [3:0] rel;
        logic [15:0] thr;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int k = 0; k < PLAN_LEN; k++)
        begin
            if (plan[k].kind == ROW_ZERO_COUNTS)
            begin
                settle();
                configure(4'd0, 4'd0, 4'd0, 16'hFFFF);
            end
            else
                send(plan[k].rd, plan[k].typed, plan[k].want);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: {act, hold, rel, thr} = {4'd1, 4'd0, 4'd1, 16'h0000};
                1: {act, hold, rel, thr} = {4'd15, 4'd15, 4'd15, 16'hFFFF};
                2: {act, hold, rel, thr} = {4'd0, 4'd0, 4'd0, 16'd39322};
                3: {act, hold, rel, thr} = {4'd2, 4'd5, 4'd3, 16'd20000};
                4: {act, hold, rel, thr} = {ACTIVATE_HITS_RST, HOLD_MISSES_RST,
                                            RELEASE_MISSES_RST, SUPPORT_THRESHOLD_RST};
                default:
                begin
                    act = 4'($urandom_range(0, 15));
                    hold = 4'($urandom_range(0, 15));
                    rel = 4'($urandom_range(0, 15));
                    thr = rand_score();
                end
            endcase
            settle();
            configure(act, hold, rel, thr);
            tx_quiet = (phase % 3 == 2);
            for (int i = 0; i < READINGS_PER_PHASE; i++)
            begin
                // Let the pipeline run dry once in the middle of a phase.
                if (phase == 1 && i == READINGS_PER_PHASE / 2)
                    settle();
                make_reading(r);
                send(r, 1'b0, '0);
            end
        end
        settle();

        $display("%0d readings under %0d register settings, %0d results checked",
                 readings_sent, settings_used, results_seen);
        $display("%0d alerts started, %0d released, %0d lingering between hold and release",
                 starts_seen, ends_seen, lingers_seen);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
